// File: rtl/dcp_pkg.sv
// Shared types, constants and lookup functions for the DC predictor.
// No dependencies; used by the interfaces, the rescale lane and the top level.
`default_nettype none
package dcp_pkg;

    localparam int DcWidth    = 12;
    localparam int QuantWidth = 6;
    localparam int PredWidth  = 16;
    localparam int ValWidth   = 17;   // rescaled neighbour value, signed
    localparam int RecipWidth = 19;
    localparam int RescaleShift = 18;
    localparam int RoundAdd   = 'h20000;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_lane_en;

    localparam logic [4:0] DcScaleTab [32] = '{
        5'd0,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8,  5'd9,  5'd9,
        5'd10, 5'd10, 5'd11, 5'd11, 5'd12, 5'd12, 5'd13, 5'd13,
        5'd14, 5'd14, 5'd15, 5'd15, 5'd16, 5'd16, 5'd17, 5'd17,
        5'd18, 5'd18, 5'd19, 5'd19, 5'd20, 5'd20, 5'd21, 5'd21
    };

    // magnitude of a quantizer, -32 saturates to 31
    function automatic logic [4:0] qmag(input logic [QuantWidth-1:0] q);
        logic [QuantWidth-1:0] m;
        m = q[QuantWidth-1] ? (~q + 1'b1) : q;
        return m[QuantWidth-1] ? 5'd31 : m[4:0];
    endfunction

    function automatic logic [4:0] dcscale(input logic [4:0] q);
        return DcScaleTab[q];
    endfunction

    // round(2^18 / s) for scales 1 to 21, covering every nonzero scale the DC table can yield; others give 0
    function automatic logic [RecipWidth-1:0] recip(input logic [4:0] s);
        logic [RecipWidth-1:0] r;
        case (s)
            5'd1:  r = 19'h40000;
            5'd2:  r = 19'h20000;
            5'd3:  r = 19'h15555;
            5'd4:  r = 19'h10000;
            5'd5:  r = 19'h0CCCD;
            5'd6:  r = 19'h0AAAB;
            5'd7:  r = 19'h09249;
            5'd8:  r = 19'h08000;
            5'd9:  r = 19'h071C7;
            5'd10: r = 19'h06666;
            5'd11: r = 19'h05D17;
            5'd12: r = 19'h05555;
            5'd13: r = 19'h04EC5;
            5'd14: r = 19'h04925;
            5'd15: r = 19'h04444;
            5'd16: r = 19'h04000;
            5'd17: r = 19'h03C3C;
            5'd18: r = 19'h038E4;
            5'd19: r = 19'h035E5;
            5'd20: r = 19'h03333;
            5'd21: r = 19'h030C3;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/dcp_if.sv
// Input and output channel interfaces of the DC predictor.
// Depends on dcp_pkg for field widths.
`default_nettype none
interface dcp_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [dcp_pkg::DcWidth-1:0]      top_dc;
    logic signed [dcp_pkg::QuantWidth-1:0]   top_quant;
    logic signed [dcp_pkg::DcWidth-1:0]      left_dc;
    logic signed [dcp_pkg::QuantWidth-1:0]   left_quant;
    logic signed [dcp_pkg::DcWidth-1:0]      corner_dc;
    logic signed [dcp_pkg::QuantWidth-1:0]   corner_quant;
    logic signed [dcp_pkg::QuantWidth-1:0]   current_quant;
    logic                                    top_present;
    logic                                    left_present;

    modport source (
        output valid, top_dc, top_quant, left_dc, left_quant, corner_dc, corner_quant,
               current_quant, top_present, left_present,
        input  ready
    );
    modport sink (
        input  valid, top_dc, top_quant, left_dc, left_quant, corner_dc, corner_quant,
               current_quant, top_present, left_present,
        output ready
    );
endinterface

interface dcp_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [dcp_pkg::PredWidth-1:0]    predicted_dc;
    logic                                    from_left;

    modport source (output valid, predicted_dc, from_left, input ready);
    modport sink   (input  valid, predicted_dc, from_left, output ready);
endinterface
`default_nettype wire

// File: rtl/dcp_rescale.sv
// One neighbour rescale lane: quantizer lookup, two multiplies, round and shift.
// Three register stages, each loaded by its stage enable. Depends on dcp_pkg.
`default_nettype none
module dcp_rescale (
    input  wire logic                                   i_clk,
    input  wire dcp_pkg::t_lane_en                      i_en,
    input  wire logic signed [dcp_pkg::DcWidth-1:0]     i_dc,
    input  wire logic [dcp_pkg::QuantWidth-1:0]         i_nq,
    input  wire logic [dcp_pkg::QuantWidth-1:0]         i_cq,
    output logic signed [dcp_pkg::ValWidth-1:0]         o_val
);
    localparam int P1Width = dcp_pkg::DcWidth + 6;
    localparam int P2Width = P1Width + dcp_pkg::RecipWidth + 1;

    logic [4:0] nq, cq, cs;

    logic signed [dcp_pkg::DcWidth-1:0]  r2_dc, r3_dc, r4_dc;
    logic [4:0]                          r2_ns;
    logic [dcp_pkg::RecipWidth-1:0]      r2_rc, r3_rc;
    logic                                r2_byp, r3_byp, r4_byp;
    logic                                r2_zro, r3_zro, r4_zro;
    logic signed [P1Width-1:0]           r3_p;
    logic signed [P2Width-1:0]           r4_t;
    logic signed [P2Width-1:0]           n4_t;

    always_comb begin
        nq = dcp_pkg::qmag(i_nq);
        cq = dcp_pkg::qmag(i_cq);
        cs = dcp_pkg::dcscale(cq);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_dc  <= i_dc;
            r2_ns  <= dcp_pkg::dcscale(nq);
            r2_rc  <= dcp_pkg::recip(cs);
            r2_byp <= (nq == 5'd0) || (nq == cq);
            r2_zro <= (cs == 5'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_p   <= P1Width'(r2_dc * $signed({1'b0, r2_ns}));
            r3_rc  <= r2_rc;
            r3_dc  <= r2_dc;
            r3_byp <= r2_byp;
            r3_zro <= r2_zro;
        end
    end

    assign n4_t = P2Width'(r3_p * $signed({1'b0, r3_rc})) + P2Width'(dcp_pkg::RoundAdd);

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r4_t   <= n4_t;
            r4_dc  <= r3_dc;
            r4_byp <= r3_byp;
            r4_zro <= r3_zro;
        end
    end

    // arithmetic shift gives the floor the rounding needs
    always_comb begin
        if (r4_byp) begin
            o_val = dcp_pkg::ValWidth'(r4_dc);
        end else if (r4_zro) begin
            o_val = '0;
        end else begin
            o_val = r4_t[dcp_pkg::RescaleShift +: dcp_pkg::ValWidth];
        end
    end

endmodule
`default_nettype wire

// File: rtl/dc_predictor_with_quant_rescale.sv
// Top level of the intra DC predictor with quantizer rescaling.
// Depends on dcp_pkg, dcp_in_if / dcp_out_if and dcp_rescale.
//
// Usage:
//   i_in  (sink)  : one transfer per block with the three neighbour DC levels,
//                   their quantizers, the current quantizer and the two
//                   availability flags.
//   o_out (source): one transfer per input with the predictor and the
//                   direction flag (1 = left, also when no neighbour exists).
//   One item is taken every cycle while i_in.ready is high; six stages
//   (input register, three rescale-lane stages with the two multiplies,
//   gradient difference, select) each hold one item.
//   Each stage has its own valid bit and loads when it is empty or its
//   successor moves, so bubbles close up while the receiver stalls; i_in.ready
//   drops only when all six stages hold data and o_out.ready is low.
//   Reset clears all valid bits; no data is lost or repeated across a stall.
`default_nettype none
module dc_predictor_with_quant_rescale (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dcp_in_if.sink      i_in,
    dcp_out_if.source   o_out
);
    localparam int VW = dcp_pkg::ValWidth;

    logic [6:1] r_v;
    logic [6:1] en;

    logic signed [dcp_pkg::DcWidth-1:0]   r1_tdc, r1_ldc, r1_cdc;
    logic [dcp_pkg::QuantWidth-1:0]       r1_tq, r1_lq, r1_cnq, r1_cq;
    logic [1:0]                           r1_pr, r2_pr, r3_pr, r4_pr;

    dcp_pkg::t_lane_en                    lane_en;
    logic signed [VW-1:0]                 va, vb, vc;
    logic signed [VW-1:0]                 a5, b5, c5;
    logic signed [VW:0]                   dab, dbc;

    logic signed [VW-1:0]                 r5_a, r5_c;
    logic [VW:0]                          r5_dab, r5_dbc;
    logic                                 r5_ta, r5_la;

    logic                                 n6_left;
    logic signed [dcp_pkg::PredWidth-1:0] r6_pred;
    logic                                 r6_fl;

    always_comb begin
        en[6] = !r_v[6] || o_out.ready;
        for (int k = 5; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_in.ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= i_in.valid;
            for (int k = 2; k <= 6; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_tdc <= i_in.top_dc;
            r1_ldc <= i_in.left_dc;
            r1_cdc <= i_in.corner_dc;
            r1_tq  <= i_in.top_quant;
            r1_lq  <= i_in.left_quant;
            r1_cnq <= i_in.corner_quant;
            r1_cq  <= i_in.current_quant;
            r1_pr  <= {i_in.top_present, i_in.left_present};
        end
        if (en[2]) r2_pr <= r1_pr;
        if (en[3]) r3_pr <= r2_pr;
        if (en[4]) r4_pr <= r3_pr;
    end

    assign lane_en = '{s2: en[2], s3: en[3], s4: en[4]};

    dcp_rescale u_top (
        .i_clk (i_clk), .i_en (lane_en), .i_dc (r1_tdc), .i_nq (r1_tq),
        .i_cq (r1_cq), .o_val (va)
    );
    dcp_rescale u_corner (
        .i_clk (i_clk), .i_en (lane_en), .i_dc (r1_cdc), .i_nq (r1_cnq),
        .i_cq (r1_cq), .o_val (vb)
    );
    dcp_rescale u_left (
        .i_clk (i_clk), .i_en (lane_en), .i_dc (r1_ldc), .i_nq (r1_lq),
        .i_cq (r1_cq), .o_val (vc)
    );

    // corner only counts when both neighbours are present
    always_comb begin
        a5  = r4_pr[1] ? va : '0;
        c5  = r4_pr[0] ? vc : '0;
        b5  = (r4_pr[1] && r4_pr[0]) ? vb : '0;
        dab = (VW+1)'(a5) - (VW+1)'(b5);
        dbc = (VW+1)'(b5) - (VW+1)'(c5);
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_a   <= a5;
            r5_c   <= c5;
            r5_dab <= dab[VW] ? (VW+1)'(-dab) : dab;
            r5_dbc <= dbc[VW] ? (VW+1)'(-dbc) : dbc;
            r5_ta  <= r4_pr[1];
            r5_la  <= r4_pr[0];
        end
    end

    assign n6_left = r5_la && (!r5_ta || (r5_dab <= r5_dbc));

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            if (n6_left) begin
                r6_pred <= dcp_pkg::PredWidth'(r5_c);
            end else if (r5_ta) begin
                r6_pred <= dcp_pkg::PredWidth'(r5_a);
            end else begin
                r6_pred <= '0;
            end
            r6_fl <= n6_left || (!r5_ta && !r5_la);
        end
    end

    assign o_out.valid        = r_v[6];
    assign o_out.predicted_dc = r6_pred;
    assign o_out.from_left    = r6_fl;

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (&r_v) && !o_out.ready)
        else $error("input stalled with room in the pipeline");

    a_advance_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.ready && r_v[5]) |=> o_out.valid)
        else $error("stage 5 item did not reach the output");

    a_top_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[5] && !r5_ta) |-> (r5_a == '0))
        else $error("absent top neighbour has nonzero value");

    a_no_neighbour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[5] && en[6] && !r5_ta && !r5_la) |=> (r6_pred == '0) && r6_fl)
        else $error("no-neighbour case gave a nonzero predictor");
`endif

endmodule
`default_nettype wire

// File: test/dcp_checker.sv
`timescale 1ns / 1ps
// Checker for the DC predictor: watches both channels, predicts each result
// from the input transfer and compares it. Depends on dcp_pkg and dcp_if.
module dcp_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dcp_in_if         i_in,
    dcp_out_if        i_out,
    output int        o_errors,
    output int        o_pending
);
    import dcp_pkg::*;

    typedef struct packed {
        logic signed [PredWidth-1:0] pred;
        logic                        from_left;
    } dc_pred_t;

    dc_pred_t expected_preds[$];
    int       mismatch_count = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // sign ignored, -32 saturates to 31
    function automatic logic [4:0] quant_mag(input logic signed [QuantWidth-1:0] q);
        int m;
        m = (q < 0) ? -int'(q) : int'(q);
        return (m > 31) ? 5'd31 : 5'(m);
    endfunction

    function automatic int dc_scale_of(input logic [4:0] q);
        if (q == 0) begin
            return 0;
        end else if (q == 1) begin
            return 2;
        end else if (q == 2) begin
            return 4;
        end else if (q < 6) begin
            return 8;
        end
        return int'(q) / 2 + 6;
    endfunction

    // round(2^18 / s)
    function automatic longint recip_of(input int s);
        return (longint'(1) << RescaleShift) / s
               + (((longint'(1) << RescaleShift) % s) * 2 >= s ? 1 : 0);
    endfunction

    function automatic longint rescale_dc(input logic signed [DcWidth-1:0] dc,
                                          input logic [4:0] nq, input logic [4:0] cq);
        int     cs;
        longint t;
        if (nq == 0 || nq == cq) return longint'(dc);
        cs = dc_scale_of(cq);
        if (cs == 0) return 0;
        t = longint'(dc) * dc_scale_of(nq) * recip_of(cs) + RoundAdd;
        return t >>> RescaleShift;
    endfunction

    function automatic longint abs_l(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic dc_pred_t model_prediction(
        input logic signed [DcWidth-1:0]    top_dc,
        input logic signed [QuantWidth-1:0] top_q,
        input logic signed [DcWidth-1:0]    left_dc,
        input logic signed [QuantWidth-1:0] left_q,
        input logic signed [DcWidth-1:0]    corner_dc,
        input logic signed [QuantWidth-1:0] corner_q,
        input logic signed [QuantWidth-1:0] cur_q,
        input logic                         top_p,
        input logic                         left_p
    );
        longint     a;
        longint     b;
        longint     c;
        logic [4:0] cq;
        logic       use_left;
        dc_pred_t   r;
        a  = 0;
        b  = 0;
        c  = 0;
        cq = quant_mag(cur_q);
        if (top_p) a = rescale_dc(top_dc, quant_mag(top_q), cq);
        if (left_p) c = rescale_dc(left_dc, quant_mag(left_q), cq);
        if (top_p && left_p) b = rescale_dc(corner_dc, quant_mag(corner_q), cq);
        use_left    = left_p && (!top_p || abs_l(a - b) <= abs_l(b - c));
        r.from_left = use_left || (!top_p && !left_p);
        if (use_left) begin
            r.pred = c[PredWidth-1:0];
        end else if (top_p) begin
            r.pred = a[PredWidth-1:0];
        end else begin
            r.pred = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
        o_errors = mismatch_count;
    endtask

    always @(posedge i_clk) begin : watch
        dc_pred_t want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) begin
                expected_preds.push_back(model_prediction(
                    i_in.top_dc, i_in.top_quant, i_in.left_dc, i_in.left_quant,
                    i_in.corner_dc, i_in.corner_quant, i_in.current_quant,
                    i_in.top_present, i_in.left_present));
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_preds.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = expected_preds.pop_front();
                    if (i_out.predicted_dc !== want.pred) begin
                        report_mismatch($sformatf("predicted_dc got %0d want %0d",
                                                  i_out.predicted_dc, want.pred));
                    end
                    if (i_out.from_left !== want.from_left) begin
                        report_mismatch($sformatf("from_left got %b want %b",
                                                  i_out.from_left, want.from_left));
                    end
                end
            end
        end
        o_pending = expected_preds.size();
    end

endmodule

// File: test/dc_predictor_with_quant_rescale_tb.sv
`timescale 1ns / 1ps
// Top of the DC predictor testbench: clock, reset, directed and random blocks
// under varying back-pressure, and the verdict. Depends on dcp_pkg, dcp_if, dcp_checker.
module dc_predictor_with_quant_rescale_tb;
    import dcp_pkg::*;

    typedef struct packed {
        logic signed [DcWidth-1:0]    top_dc;
        logic signed [QuantWidth-1:0] top_quant;
        logic signed [DcWidth-1:0]    left_dc;
        logic signed [QuantWidth-1:0] left_quant;
        logic signed [DcWidth-1:0]    corner_dc;
        logic signed [QuantWidth-1:0] corner_quant;
        logic signed [QuantWidth-1:0] current_quant;
        logic                         top_present;
        logic                         left_present;
    } dc_block_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   in_idle_pct  = 0;
    int   out_idle_pct = 0;
    int   errors;
    int   pending;

    dcp_in_if  in_ch ();
    dcp_out_if out_ch ();

    dc_predictor_with_quant_rescale i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    dcp_checker i_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (in_ch),
        .i_out    (out_ch),
        .o_errors (errors),
        .o_pending(pending)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(0, 99) >= out_idle_pct);
    end

    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic dc_block_t mk(input int tdc, input int tq, input int ldc, input int lq,
                                     input int cdc, input int bq, input int cq,
                                     input bit tp, input bit lp);
        dc_block_t b;
        b.top_dc        = tdc[DcWidth-1:0];
        b.top_quant     = tq[QuantWidth-1:0];
        b.left_dc       = ldc[DcWidth-1:0];
        b.left_quant    = lq[QuantWidth-1:0];
        b.corner_dc     = cdc[DcWidth-1:0];
        b.corner_quant  = bq[QuantWidth-1:0];
        b.current_quant = cq[QuantWidth-1:0];
        b.top_present   = tp;
        b.left_present  = lp;
        return b;
    endfunction

    function automatic logic signed [DcWidth-1:0] rand_dc();
        case ($urandom_range(0, 9))
            0:       return -12'sd2048;
            1:       return 12'sd2047;
            2:       return 12'(int'($urandom_range(0, 15)) - 8);
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic signed [QuantWidth-1:0] rand_quant(
        input logic signed [QuantWidth-1:0] cq);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return cq;
            2:       return -cq;
            3:       return -6'sd32;
            default: return 6'($urandom);
        endcase
    endfunction

    function automatic dc_block_t rand_block();
        dc_block_t b;
        int        sel;
        b.current_quant = ($urandom_range(0, 9) == 0) ? '0 : 6'($urandom);
        b.top_dc        = rand_dc();
        b.left_dc       = rand_dc();
        b.corner_dc     = rand_dc();
        b.top_quant     = rand_quant(b.current_quant);
        b.left_quant    = rand_quant(b.current_quant);
        b.corner_quant  = rand_quant(b.current_quant);
        sel = $urandom_range(0, 9);
        b.top_present   = (sel < 7) || (sel == 7);
        b.left_present  = (sel < 7) || (sel == 8);
        // equal neighbours give a gradient tie
        if ($urandom_range(0, 9) == 0) begin
            b.left_dc    = b.top_dc;
            b.left_quant = b.top_quant;
        end
        return b;
    endfunction

    task automatic send_block(input dc_block_t b);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid         = 1'b1;
        in_ch.top_dc        = b.top_dc;
        in_ch.top_quant     = b.top_quant;
        in_ch.left_dc       = b.left_dc;
        in_ch.left_quant    = b.left_quant;
        in_ch.corner_dc     = b.corner_dc;
        in_ch.corner_quant  = b.corner_quant;
        in_ch.current_quant = b.current_quant;
        in_ch.top_present   = b.top_present;
        in_ch.left_present  = b.left_present;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        dc_block_t directed[$];
        in_ch.valid         = 1'b0;
        in_ch.top_dc        = '0;
        in_ch.top_quant     = '0;
        in_ch.left_dc       = '0;
        in_ch.left_quant    = '0;
        in_ch.corner_dc     = '0;
        in_ch.corner_quant  = '0;
        in_ch.current_quant = '0;
        in_ch.top_present   = 1'b0;
        in_ch.left_present  = 1'b0;
        out_ch.ready        = 1'b0;
        i_rst_n             = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // no neighbour, top only, left only
        directed.push_back(mk(2047, 31, -2048, -31, 2047, 31, 5, 0, 0));
        directed.push_back(mk(2047, 0, 0, 0, 0, 0, 9, 1, 0));
        directed.push_back(mk(0, 0, -2048, 0, 0, 0, 9, 0, 1));
        // largest upscale, both signs
        directed.push_back(mk(2047, 31, 0, 0, 0, 0, 1, 1, 0));
        directed.push_back(mk(0, 0, -2048, 31, 0, 0, -1, 0, 1));
        directed.push_back(mk(-2048, -31, 2047, 30, -2048, 29, 1, 1, 1));
        // current scale zero
        directed.push_back(mk(1000, 7, -1000, 12, 500, 3, 0, 1, 1));
        directed.push_back(mk(1000, 0, -1000, 0, 500, 0, 0, 1, 1));
        // -32 saturates to 31 before the equality test
        directed.push_back(mk(-777, -32, 333, 31, 55, 31, 31, 1, 1));
        directed.push_back(mk(-777, 31, 333, 5, 55, -32, -32, 1, 1));
        directed.push_back(mk(2047, 5, -2048, 2, 0, 1, -32, 1, 1));
        // equal magnitude, opposite sign: no rescale
        directed.push_back(mk(123, -7, 456, 7, 789, -7, 7, 1, 1));
        // gradient tie, clear left, clear top
        directed.push_back(mk(100, 4, 100, 4, 0, 4, 4, 1, 1));
        directed.push_back(mk(0, 3, 500, 3, 0, 3, 3, 1, 1));
        directed.push_back(mk(500, 3, 0, 3, 0, 3, 3, 1, 1));
        // rounding of small negative and positive values
        directed.push_back(mk(-1, 1, -1, 2, -1, 3, 31, 1, 1));
        directed.push_back(mk(1, 1, 1, 2, -1, 3, 31, 1, 1));
        directed.push_back(mk(-2048, 31, 2047, 31, -2048, 31, 2, 1, 1));
        directed.push_back(mk(2047, -31, -2048, -31, 2047, -31, -2, 1, 1));
        directed.push_back(mk(-2048, 0, -2048, 0, 2047, 0, -31, 1, 1));

        foreach (directed[i]) send_block(directed[i]);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    in_idle_pct  = 7;
                    out_idle_pct = 84;
                end
                1: begin
                    in_idle_pct  = 84;
                    out_idle_pct = 7;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            repeat (400) send_block(rand_block());
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
